// ----- hw/rtl/lpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MAXLEN_W   = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXLEN = 2'd2;

    localparam logic [31:0]         HEAD_RESET   = 32'h0117_1701;
    localparam logic [31:0]         TAIL_RESET   = 32'h0417_1704;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd10485748;

    // result kinds
    localparam logic [1:0] KIND_BODY = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error causes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_HEAD = 2'd1;
    localparam logic [1:0] CAUSE_LEN  = 2'd2;
    localparam logic [1:0] CAUSE_TAIL = 2'd3;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] body_byte;
        logic [1:0] error_cause;
    } result_t;

    // byte idx of a pattern, first byte in bits 31..24
    function automatic logic [7:0] pattern_byte(input logic [31:0] pat,
                                                input logic [1:0]  idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = pat[31:24];
            2'd1:    b = pat[23:16];
            2'd2:    b = pat[15:8];
            default: b = pat[7:0];
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/lpfd_out_buf.sv -----
// ----------------------------------------------------------------------------
// lpfd_out_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module lpfd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lpfd_pkg::result_t push_res,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output lpfd_pkg::result_t out_res
);
    import lpfd_pkg::*;

    logic    main_valid_reg;
    result_t main_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no push possible here; refill main from skid
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= push_res;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // skid holds only while main is full
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage full with empty output register");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid item changed while output stalled");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("item pushed into a full buffer");

endmodule

// ----- hw/rtl/length_prefixed_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Recovers frames (head, LE signed length, body, tail) from a byte stream.
// ----------------------------------------------------------------------------
//
//  channel   ports                                    dir   handshake
//  -------   ---------------------------------------  ----  -------------
//  input     s_valid s_ready s_rx_byte                in    valid/ready
//  result    m_valid m_ready m_result_kind            out   valid/ready
//            m_body_byte m_error_cause
//  config    cfg_wr_en cfg_wr_index cfg_wr_data       in    write enable
//
//  One byte per cycle while s_ready is high. Each accepted byte updates the
//  parser state at the accepting edge; its result, if any, is registered at
//  that same edge, in the output register or, while that is full, the skid stage.
//  A two-entry result buffer (output register plus skid stage) keeps input
//  flowing while one result waits; s_ready drops only when both are full.
//  Reset (aresetn low, synchronous) returns to head hunt and reloads the
//  registers with their default patterns and maximum length.
//
module length_prefixed_frame_deframer #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_result_kind,
    output logic [7:0]                        m_body_byte,
    output logic [1:0]                        m_error_cause,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import lpfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_TAIL
    } phase_t;

    // configuration registers
    logic [31:0]             head_pattern_reg;
    logic [31:0]             tail_pattern_reg;
    logic [MAXLEN_W-1:0]     max_body_length_reg;

    // parser state
    phase_t                  phase_reg,          phase_next;
    logic [1:0]              pat_idx_reg,        pat_idx_next;
    logic [23:0]             len_bytes_reg,      len_bytes_next;
    logic [LENGTH_WIDTH-1:0] body_rem_reg,       body_rem_next;
    logic                    err_reported_reg,   err_reported_next;

    logic                    accept;
    logic                    res_valid;
    result_t                 res;
    result_t                 out_res;
    logic [31:0]             full_len;
    logic                    len_bad;
    logic [7:0]              head_byte;
    logic [7:0]              head_first;
    logic [7:0]              tail_byte;

    assign accept     = s_valid && s_ready;
    assign head_byte  = pattern_byte(head_pattern_reg, pat_idx_reg);
    assign head_first = pattern_byte(head_pattern_reg, 2'd0);
    assign tail_byte  = pattern_byte(tail_pattern_reg, pat_idx_reg);

    // length is complete with the fourth byte, which is the top byte
    assign full_len = {s_rx_byte, len_bytes_reg};
    assign len_bad  = full_len[31] || (full_len == 32'd0)
                   || (full_len > {{(32 - MAXLEN_W){1'b0}}, max_body_length_reg})
                   || (|full_len[31:LENGTH_WIDTH]);

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_pattern_reg    <= HEAD_RESET;
            tail_pattern_reg    <= TAIL_RESET;
            max_body_length_reg <= MAXLEN_RESET;
        end else if (cfg_wr_en) begin
            // indexes beyond the list are dropped
            if (cfg_wr_index == REG_HEAD) begin
                head_pattern_reg <= cfg_wr_data;
            end else if (cfg_wr_index == REG_TAIL) begin
                tail_pattern_reg <= cfg_wr_data;
            end else if (cfg_wr_index == REG_MAXLEN) begin
                max_body_length_reg <= cfg_wr_data[MAXLEN_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // per-byte parser step
    // ------------------------------------------------------------------
    always_comb begin
        phase_next        = phase_reg;
        pat_idx_next      = pat_idx_reg;
        len_bytes_next    = len_bytes_reg;
        body_rem_next     = body_rem_reg;
        err_reported_next = err_reported_reg;
        res_valid         = 1'b0;
        res.result_kind   = KIND_BODY;
        res.body_byte     = 8'd0;
        res.error_cause   = CAUSE_NONE;

        unique case (phase_reg)
            PH_HUNT: begin
                if (s_rx_byte == head_byte) begin
                    if (pat_idx_reg == 2'd3) begin
                        phase_next        = PH_LEN;
                        pat_idx_next      = 2'd0;
                        len_bytes_next    = 24'd0;
                        err_reported_next = 1'b0;
                    end else begin
                        pat_idx_next = pat_idx_reg + 2'd1;
                    end
                end else begin
                    // restart the match on this byte if it opens a head
                    pat_idx_next = (s_rx_byte == head_first) ? 2'd1 : 2'd0;
                    if (!err_reported_reg) begin
                        err_reported_next = 1'b1;
                        res_valid         = 1'b1;
                        res.result_kind   = KIND_ERR;
                        res.error_cause   = CAUSE_HEAD;
                    end
                end
            end
            PH_LEN: begin
                len_bytes_next = {s_rx_byte, len_bytes_reg[23:8]};
                if (pat_idx_reg != 2'd3) begin
                    pat_idx_next = pat_idx_reg + 2'd1;
                end else begin
                    pat_idx_next = 2'd0;
                    if (len_bad) begin
                        phase_next        = PH_HUNT;
                        err_reported_next = 1'b1;
                        res_valid         = 1'b1;
                        res.result_kind   = KIND_ERR;
                        res.error_cause   = CAUSE_LEN;
                    end else begin
                        body_rem_next = full_len[LENGTH_WIDTH-1:0];
                        phase_next    = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                res_valid     = 1'b1;
                res.body_byte = s_rx_byte;
                body_rem_next = body_rem_reg - LENGTH_WIDTH'(1);
                if (body_rem_reg == LENGTH_WIDTH'(1)) begin
                    phase_next   = PH_TAIL;
                    pat_idx_next = 2'd0;
                end
            end
            default: begin
                if (s_rx_byte != tail_byte) begin
                    // drop the mismatching byte and hunt again
                    phase_next        = PH_HUNT;
                    pat_idx_next      = 2'd0;
                    err_reported_next = 1'b1;
                    res_valid         = 1'b1;
                    res.result_kind   = KIND_ERR;
                    res.error_cause   = CAUSE_TAIL;
                end else if (pat_idx_reg != 2'd3) begin
                    pat_idx_next = pat_idx_reg + 2'd1;
                end else begin
                    phase_next      = PH_HUNT;
                    pat_idx_next    = 2'd0;
                    res_valid       = 1'b1;
                    res.result_kind = KIND_GOOD;
                end
            end
        endcase
    end

    // hold state unless an item is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            pat_idx_reg      <= 2'd0;
            len_bytes_reg    <= 24'd0;
            body_rem_reg     <= '0;
            err_reported_reg <= 1'b0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            pat_idx_reg      <= pat_idx_next;
            len_bytes_reg    <= len_bytes_next;
            body_rem_reg     <= body_rem_next;
            err_reported_reg <= err_reported_next;
        end
    end

    // ------------------------------------------------------------------
    // result buffer
    // ------------------------------------------------------------------
    lpfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_res  (res),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_result_kind = out_res.result_kind;
    assign m_body_byte   = out_res.body_byte;
    assign m_error_cause = out_res.error_cause;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_body_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (body_rem_reg != '0))
        else $error("body phase with no bytes remaining");

    a_body_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (pat_idx_reg == 2'd0))
        else $error("pattern index not cleared in body phase");

    a_tail_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_TAIL && s_rx_byte != tail_byte)
        |=> (phase_reg == PH_HUNT && err_reported_reg))
        else $error("tail mismatch did not return to hunt");

    a_cause_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_ERR) |-> (m_error_cause == CAUSE_NONE))
        else $error("error cause on a non-error result");

endmodule
